[hdl/rmvs_pkg.sv]
`default_nettype none
package rmvs_pkg;

    // sample field as it appears on the bus, and the bits of it that are used
    localparam int X_W      = 32;
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;

    // running mean carries extra fraction bits beyond the sample format
    localparam int EXT_BITS = 16;
    localparam int MEAN_W   = X_W + EXT_BITS;
    localparam int DIFF_W   = MEAN_W + 1;
    localparam int MAG_W    = MEAN_W;

    // sum of squared deviations, variance and root
    localparam int SUM_W    = 64;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int ALU_W    = REM_W + 2;
    localparam int STEP_W   = $clog2(SUM_W);

    // deviation product, taken a 16-bit slice of one operand per cycle
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = MAG_W / MUL_CHUNK;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int PROD_W    = 2 * MAG_W;

    typedef logic [0:0] alu_op_t;
    localparam alu_op_t OP_DIV  = 1'b0;
    localparam alu_op_t OP_SQRT = 1'b1;

    typedef struct packed {
        alu_op_t             op;
        logic [REM_W-1:0]    rem;
        logic [SUM_W-1:0]    quo;
        logic [ROOT_W-1:0]   root;
        logic [COUNT_W-1:0]  divisor;
    } alu_in_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [SUM_W-1:0]    quo;
        logic [ROOT_W-1:0]   root;
    } alu_out_t;

endpackage
`default_nettype wire

[hdl/rmvs_alu.sv]
`default_nettype none
// one restoring step: a divide bit or a square-root bit through one subtractor
module rmvs_alu
(
    input  wire rmvs_pkg::alu_in_t  req,
    output rmvs_pkg::alu_out_t      rsp
);

    logic [rmvs_pkg::ALU_W-1:0] trial;
    logic [rmvs_pkg::ALU_W-1:0] subtrahend;
    logic [rmvs_pkg::ALU_W:0]   diff;
    logic                       ge;

    always_comb
    begin
        trial      = '0;
        subtrahend = '0;
        unique case (req.op)
            rmvs_pkg::OP_DIV:
            begin
                trial = rmvs_pkg::ALU_W'({req.rem[rmvs_pkg::COUNT_W-1:0],
                                          req.quo[rmvs_pkg::SUM_W-1]});
                subtrahend = rmvs_pkg::ALU_W'(req.divisor);
            end
            rmvs_pkg::OP_SQRT:
            begin
                trial = {req.rem, req.quo[rmvs_pkg::SUM_W-1 -: 2]};
                subtrahend = rmvs_pkg::ALU_W'({req.root, 2'b01});
            end
            default:
            begin
                trial      = '0;
                subtrahend = '0;
            end
        endcase

        diff = {1'b0, trial} - {1'b0, subtrahend};
        ge   = !diff[rmvs_pkg::ALU_W];

        rsp.rem = ge ? diff[rmvs_pkg::REM_W-1:0] : trial[rmvs_pkg::REM_W-1:0];

        unique case (req.op)
            rmvs_pkg::OP_DIV:
            begin
                rsp.quo  = {req.quo[rmvs_pkg::SUM_W-2:0], ge};
                rsp.root = req.root;
            end
            rmvs_pkg::OP_SQRT:
            begin
                rsp.quo  = {req.quo[rmvs_pkg::SUM_W-3:0], 2'b00};
                rsp.root = {req.root[rmvs_pkg::ROOT_W-2:0], ge};
            end
            default:
            begin
                rsp.quo  = req.quo;
                rsp.root = req.root;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/rmvs_mul.sv]
`default_nettype none
// deviation product, high slice of b first, result is floor(a * b / 2^32)
module rmvs_mul
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire [rmvs_pkg::MAG_W-1:0]     a,
    input  wire [rmvs_pkg::MAG_W-1:0]     b,
    output logic                          done,
    output logic [rmvs_pkg::SUM_W-1:0]    product
);

    logic [rmvs_pkg::PROD_W-1:0]                     acc_reg, acc_next;
    logic [rmvs_pkg::MAG_W-1:0]                      b_reg, b_next;
    logic [rmvs_pkg::MUL_CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                                            busy_reg, busy_next;
    logic                                            done_reg, done_next;
    logic [rmvs_pkg::MAG_W+rmvs_pkg::MUL_CHUNK-1:0]  part;

    always_comb
    begin
        part = a * b_reg[rmvs_pkg::MAG_W-1 -: rmvs_pkg::MUL_CHUNK];
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = rmvs_pkg::MUL_CNT_W'(rmvs_pkg::MUL_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[rmvs_pkg::PROD_W-rmvs_pkg::MUL_CHUNK-1:0],
                        {rmvs_pkg::MUL_CHUNK{1'b0}}} + rmvs_pkg::PROD_W'(part);
            b_next   = {b_reg[rmvs_pkg::MAG_W-rmvs_pkg::MUL_CHUNK-1:0],
                        {rmvs_pkg::MUL_CHUNK{1'b0}}};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rmvs_pkg::MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[rmvs_pkg::PROD_W-1 -: rmvs_pkg::SUM_W];

endmodule
`default_nettype wire

[hdl/running_mean_variance_stats.sv]
`default_nettype none
// running statistics over a stream of signed Q16.16 samples, Welford update.
// each accepted sample gives one result beat with the count, minimum, maximum,
// mean (Q16.16), sample variance (Q32.32, zero while the count is at most one)
// and its square root (Q16.16); minimum, maximum and mean are zero before the
// first sample. once the count reaches all ones further samples are accepted but
// left out: the beat repeats the current figures and tuser is set. the sum of
// squared deviations saturates. from acceptance to its result a sample passes
// through a 48-step divide of the mean step by the count, a 3-step deviation
// product with its start and handoff, a 64-step divide of the sum by count-1
// and a 32-step square root, the divides and the root sharing one restoring
// subtract unit at one bit per cycle. the first sample skips both divides and
// the product; a dropped sample skips the first divide and the product. the
// input is ready only while no sample is being worked on, which is again the
// cycle after a result is loaded, so a new sample is accepted only once the
// last one's result is loaded; a finished result waits in the output register,
// so the next sample may be accepted before it is taken.
module running_mean_variance_stats
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [31:0]  s_tdata,   // sample
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [223:0] m_tdata,   // count, minimum, maximum, mean, variance, std_dev
    output logic         m_tuser    // dropped
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_DIV1   = 4'd2;
    localparam logic [3:0] S_MEAN   = 4'd3;
    localparam logic [3:0] S_DEV    = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MWAIT  = 4'd6;
    localparam logic [3:0] S_ACC    = 4'd7;
    localparam logic [3:0] S_VPREP  = 4'd8;
    localparam logic [3:0] S_DIV2   = 4'd9;
    localparam logic [3:0] S_SQPREP = 4'd10;
    localparam logic [3:0] S_SQRT   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    // sequencer
    logic [3:0]                          state_reg, state_next;
    logic [rmvs_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                                out_valid_reg, out_valid_next;

    // accumulated statistics
    logic [rmvs_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic signed [rmvs_pkg::MEAN_W-1:0]  mean_reg, mean_next;
    logic [rmvs_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic signed [rmvs_pkg::X_W-1:0]     min_reg, min_next;
    logic signed [rmvs_pkg::X_W-1:0]     max_reg, max_next;

    // per-sample working values
    logic signed [rmvs_pkg::X_W-1:0]     x_reg, x_next;
    logic                                neg_reg, neg_next;
    logic [rmvs_pkg::MAG_W-1:0]          mag_reg, mag_next;
    logic [rmvs_pkg::MAG_W-1:0]          mag2_reg, mag2_next;
    logic signed [rmvs_pkg::MEAN_W-1:0]  nm_reg, nm_next;
    logic                                drop_reg, drop_next;
    logic [rmvs_pkg::SUM_W-1:0]          var_reg, var_next;

    // shared restoring unit operands
    logic [rmvs_pkg::SUM_W-1:0]          quo_reg, quo_next;
    logic [rmvs_pkg::REM_W-1:0]          rem_reg, rem_next;
    logic [rmvs_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic [rmvs_pkg::COUNT_W-1:0]        div_reg, div_next;

    // result beat
    logic [223:0]                        out_data_reg, out_data_next;
    logic                                out_user_reg, out_user_next;

    rmvs_pkg::alu_in_t                   alu_req;
    rmvs_pkg::alu_out_t                  alu_rsp;

    logic                                mul_start;
    logic                                mul_done;
    logic [rmvs_pkg::SUM_W-1:0]          mul_product;

    logic signed [rmvs_pkg::X_W-1:0]     x_in;
    logic signed [rmvs_pkg::MEAN_W-1:0]  xe;
    logic signed [rmvs_pkg::DIFF_W-1:0]  d1;
    logic signed [rmvs_pkg::DIFF_W-1:0]  d2;
    logic [rmvs_pkg::DIFF_W-1:0]         d1_abs;
    logic [rmvs_pkg::DIFF_W-1:0]         d2_abs;
    logic signed [rmvs_pkg::MEAN_W-1:0]  q_signed;
    logic [rmvs_pkg::SUM_W:0]            sum_ext;

    rmvs_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rmvs_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag_reg),
        .b       (mag2_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // shared unit runs divide steps except while extracting the root
    always_comb
    begin
        alu_req.op      = (state_reg == S_SQRT) ? rmvs_pkg::OP_SQRT : rmvs_pkg::OP_DIV;
        alu_req.rem     = rem_reg;
        alu_req.quo     = quo_reg;
        alu_req.root    = root_reg;
        alu_req.divisor = div_reg;
    end

    // datapath pieces around the sequencer
    always_comb
    begin
        // only the low SAMPLE_W bits count, sign-extended
        x_in     = rmvs_pkg::X_W'($signed(s_tdata[rmvs_pkg::SAMPLE_W-1:0]));
        xe       = {x_reg, {rmvs_pkg::EXT_BITS{1'b0}}};
        d1       = {xe[rmvs_pkg::MEAN_W-1], xe} - {mean_reg[rmvs_pkg::MEAN_W-1], mean_reg};
        d1_abs   = d1[rmvs_pkg::DIFF_W-1] ? -d1 : d1;
        // mean step magnitude, quotient of the first divide
        q_signed = quo_reg[rmvs_pkg::MAG_W-1:0];
        d2       = {xe[rmvs_pkg::MEAN_W-1], xe} - {nm_reg[rmvs_pkg::MEAN_W-1], nm_reg};
        d2_abs   = d2[rmvs_pkg::DIFF_W-1] ? -d2 : d2;
        sum_ext  = {1'b0, sum_reg} + {1'b0, mul_product};
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        x_next         = x_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        mag2_next      = mag2_reg;
        nm_next        = nm_reg;
        drop_next      = drop_reg;
        var_next       = var_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        div_next       = div_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        mul_start      = 1'b0;

        // result beat leaves when taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = x_in;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                drop_next = (count_reg == '1);
                if (count_reg == '1)
                begin
                    // full count: state untouched, figures reported again
                    state_next = S_VPREP;
                end
                else if (count_reg == '0)
                begin
                    // first sample sets everything directly
                    min_next   = x_reg;
                    max_next   = x_reg;
                    mean_next  = xe;
                    sum_next   = '0;
                    count_next = rmvs_pkg::COUNT_W'(1);
                    state_next = S_VPREP;
                end
                else
                begin
                    if (x_reg < min_reg)
                    begin
                        min_next = x_reg;
                    end
                    if (x_reg > max_reg)
                    begin
                        max_next = x_reg;
                    end
                    neg_next   = d1[rmvs_pkg::DIFF_W-1];
                    mag_next   = d1_abs[rmvs_pkg::MAG_W-1:0];
                    // dividend sits at the top of the shift register
                    quo_next   = {d1_abs[rmvs_pkg::MAG_W-1:0],
                                  {(rmvs_pkg::SUM_W-rmvs_pkg::MAG_W){1'b0}}};
                    rem_next   = '0;
                    div_next   = count_reg + 1'b1;
                    step_next  = rmvs_pkg::STEP_W'(rmvs_pkg::MAG_W - 1);
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                quo_next  = alu_rsp.quo;
                rem_next  = alu_rsp.rem;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_MEAN;
                end
            end
            S_MEAN:
            begin
                // mean moves toward the sample by the truncated step
                nm_next    = neg_reg ? (mean_reg - q_signed) : (mean_reg + q_signed);
                state_next = S_DEV;
            end
            S_DEV:
            begin
                mag2_next  = d2_abs[rmvs_pkg::MAG_W-1:0];
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                mul_start  = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                // saturating accumulate of the deviation product
                sum_next   = sum_ext[rmvs_pkg::SUM_W] ? '1 : sum_ext[rmvs_pkg::SUM_W-1:0];
                mean_next  = nm_reg;
                count_next = count_reg + 1'b1;
                state_next = S_VPREP;
            end
            S_VPREP:
            begin
                rem_next = '0;
                if (count_reg > rmvs_pkg::COUNT_W'(1))
                begin
                    quo_next   = sum_reg;
                    div_next   = count_reg - 1'b1;
                    step_next  = rmvs_pkg::STEP_W'(rmvs_pkg::SUM_W - 1);
                    state_next = S_DIV2;
                end
                else
                begin
                    quo_next   = '0;
                    state_next = S_SQPREP;
                end
            end
            S_DIV2:
            begin
                quo_next  = alu_rsp.quo;
                rem_next  = alu_rsp.rem;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_SQPREP;
                end
            end
            S_SQPREP:
            begin
                // variance stays in the shift register as the radicand
                var_next   = quo_reg;
                rem_next   = '0;
                root_next  = '0;
                step_next  = rmvs_pkg::STEP_W'(rmvs_pkg::ROOT_W - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                quo_next  = alu_rsp.quo;
                rem_next  = alu_rsp.rem;
                root_next = alu_rsp.root;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {root_reg,
                                      var_reg,
                                      mean_reg[rmvs_pkg::MEAN_W-1 -: rmvs_pkg::X_W],
                                      max_reg,
                                      min_reg,
                                      32'(count_reg)};
                    out_user_next  = drop_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            mean_reg      <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        mag2_reg     <= mag2_next;
        nm_reg       <= nm_next;
        drop_reg     <= drop_next;
        var_reg      <= var_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        div_reg      <= div_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a dropped sample only happens with the count saturated
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'hFFFF_FFFF))
        else $error("dropped beat without a full count");

    // no variance until two samples are in
    a_var_small_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[31:1] == 31'd0)) |-> (m_tdata[191:128] == 64'd0))
        else $error("variance nonzero with count at most one");

    // the mean always lies between the extremes
    a_mean_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[31:0] != 32'd0)) |->
        (($signed(m_tdata[63:32]) <= $signed(m_tdata[127:96]))
         && ($signed(m_tdata[127:96]) <= $signed(m_tdata[95:64]))))
        else $error("mean outside minimum and maximum");

endmodule
`default_nettype wire
